>>> hdl/stip_pkg.sv
// Shared types, constants and helpers for the string-to-integer parser.
package stip_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned NUMBER_W = 64;
  localparam int unsigned COUNT_W  = 16;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [RADIX_W-1:0]  radix_t;
  typedef logic [NUMBER_W-1:0] number_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam radix_t RADIX_RESET = radix_t'(10);
  localparam radix_t RADIX_AUTO  = radix_t'(0);
  localparam radix_t BASE_OCT    = radix_t'(8);
  localparam radix_t BASE_DEC    = radix_t'(10);
  localparam radix_t BASE_HEX    = radix_t'(16);

  localparam count_t COUNT_MAX = '1;

  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_TAB   = 8'h09;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_LC_A  = 8'h61;
  localparam char_t CHAR_LC_X  = 8'h78;
  localparam char_t CHAR_LC_Z  = 8'h7A;
  localparam char_t CHAR_UC_A  = 8'h41;
  localparam char_t CHAR_UC_Z  = 8'h5A;

  // Digit value of a character; valid is low when it is no digit at all.
  typedef struct packed {
    logic   valid;
    radix_t value;
  } digit_t;

  function automatic digit_t digit_of(char_t c);
    digit_t d;
    d.valid = 1'b1;
    d.value = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.value = radix_t'(c - CHAR_ZERO);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      d.value = radix_t'(c - CHAR_LC_A) + BASE_DEC;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      d.value = radix_t'(c - CHAR_UC_A) + BASE_DEC;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> hdl/stip_in_if.sv
// Character stream channel: one byte and a restart flag per transaction.
interface stip_in_if;
  logic                valid;
  logic                ready;
  stip_pkg::char_t     character;
  logic                restart;

  modport source (output valid, output character, output restart, input ready);
  modport sink   (input valid, input character, input restart, output ready);
endinterface

>>> hdl/stip_out_if.sv
// Result channel: converted value and consumed character count per transaction.
interface stip_out_if;
  logic                valid;
  logic                ready;
  stip_pkg::number_t   number;
  stip_pkg::count_t    consumed_count;

  modport source (output valid, output number, output consumed_count, input ready);
  modport sink   (input valid, input number, input consumed_count, output ready);
endinterface

>>> hdl/string_to_integer_parser_unit.sv
// Streaming strtol-style parser of a character stream into a signed 64-bit value.
// Throughput: one character per cycle while no result waits in the skid register;
// the parse state and the terminating character's result are registered on accept.
// A two-entry output stage (result register plus skid register) keeps input open
// while one result waits.
// Reset (rst_n low, synchronous): radix 10, parser idle at whitespace skip, no results.
module string_to_integer_parser_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  stip_pkg::radix_t      cfg_wdata,
  stip_in_if.sink               in_stream,
  stip_out_if.source            out_stream
);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    stip_pkg::number_t number;
    stip_pkg::count_t  consumed_count;
  } result_t;

  stip_pkg::radix_t  radix_r;
  phase_t            phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  stip_pkg::number_t acc_r, acc_nxt;
  stip_pkg::radix_t  base_r, base_nxt;
  stip_pkg::count_t  pos_r, pos_nxt;

  logic              out_v_r, skid_v_r;
  result_t           out_r, skid_r;

  logic              accept, emit, pop;
  result_t           res;

  stip_pkg::char_t   c;
  stip_pkg::digit_t  dig;
  logic              consume, go_prefix, go_digits;
  logic [stip_pkg::NUMBER_W+stip_pkg::RADIX_W-1:0] prod;

  assign c      = in_stream.character;
  assign dig    = stip_pkg::digit_of(c);
  assign accept = in_stream.valid && in_stream.ready;
  assign pop    = out_v_r && out_stream.ready;

  assign in_stream.ready          = !skid_v_r;
  assign out_stream.valid         = out_v_r;
  assign out_stream.number        = out_r.number;
  assign out_stream.consumed_count = out_r.consumed_count;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    pos_nxt   = pos_r;
    consume   = 1'b0;
    go_prefix = 1'b0;
    go_digits = 1'b0;
    emit      = 1'b0;
    prod      = '0;

    if (in_stream.restart) begin
      phase_nxt = PH_SPACE;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      base_nxt  = '0;
      pos_nxt   = '0;
    end

    case (phase_nxt)
      PH_SPACE: begin
        if (c == stip_pkg::CHAR_SPACE || c == stip_pkg::CHAR_TAB) begin
          consume = 1'b1;
        end else if (c == stip_pkg::CHAR_PLUS || c == stip_pkg::CHAR_MINUS) begin
          neg_nxt   = (c == stip_pkg::CHAR_MINUS);
          consume   = 1'b1;
          phase_nxt = PH_PREFIX;
        end else begin
          go_prefix = 1'b1;
        end
      end
      PH_PREFIX: go_prefix = 1'b1;
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (c == stip_pkg::CHAR_LC_X) begin
          base_nxt = stip_pkg::BASE_HEX;
          consume  = 1'b1;
        end else begin
          go_digits = 1'b1;
        end
      end
      PH_DIGITS: go_digits = 1'b1;
      default: ;
    endcase

    if (go_prefix) begin
      if ((radix_r == stip_pkg::RADIX_AUTO || radix_r == stip_pkg::BASE_HEX) &&
          c == stip_pkg::CHAR_ZERO) begin
        base_nxt  = (radix_r == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_OCT
                                                      : stip_pkg::BASE_HEX;
        acc_nxt   = '0;
        consume   = 1'b1;
        phase_nxt = PH_ZERO;
      end else begin
        base_nxt  = (radix_r == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_DEC : radix_r;
        go_digits = 1'b1;
      end
    end

    if (go_digits) begin
      if (dig.valid && dig.value < base_nxt) begin
        prod      = acc_nxt * base_nxt;
        acc_nxt   = prod[stip_pkg::NUMBER_W-1:0] +
                    stip_pkg::number_t'(dig.value);
        consume   = 1'b1;
        phase_nxt = PH_DIGITS;
      end else begin
        phase_nxt = PH_DONE;
        emit      = 1'b1;
      end
    end

    if (consume && pos_nxt != stip_pkg::COUNT_MAX) begin
      pos_nxt = pos_nxt + 1'b1;
    end

    res.number         = neg_nxt ? (stip_pkg::number_t'(0) - acc_nxt) : acc_nxt;
    res.consumed_count = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= stip_pkg::RADIX_RESET;
      phase_r  <= PH_SPACE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      base_r   <= '0;
      pos_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
      end
      if (skid_v_r) begin
        if (pop) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (accept && emit) begin
        if (!out_v_r || pop) begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end else begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule
